/* hdl/sgdlr_pkg.sv */
// ----------------------------------------------------------------------------
// SGD linear regression trainer package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package sgdlr_pkg;

    localparam int OPERAND_W = 64;
    localparam int PRODUCT_W = 128;
    localparam int CHUNK_W   = 32;

    localparam logic [1:0] CMD_TRAIN   = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_RELOAD  = 2'd2;

    localparam logic [2:0] CFG_LEARNING_RATE      = 3'd0;
    localparam logic [2:0] CFG_COST_THRESHOLD     = 3'd1;
    localparam logic [2:0] CFG_INITIAL_BIAS       = 3'd2;
    localparam logic [2:0] CFG_INITIAL_WEIGHT_ONE = 3'd3;
    localparam logic [2:0] CFG_INITIAL_WEIGHT_TWO = 3'd4;

    localparam logic [39:0]        LEARNING_RATE_RESET      = 40'd2814750;
    localparam logic [47:0]        COST_THRESHOLD_RESET     = 48'd6554;
    localparam logic signed [47:0] INITIAL_BIAS_RESET       = 48'sd42949673;
    localparam logic signed [47:0] INITIAL_WEIGHT_ONE_RESET = 48'sd38654705;
    localparam logic signed [47:0] INITIAL_WEIGHT_TWO_RESET = 48'sd128849019;

    typedef struct packed {
        logic                 start;
        logic [OPERAND_W-1:0] a;
        logic [OPERAND_W-1:0] b;
    } sgdlr_mac_req_t;

    typedef struct packed {
        logic                 done;
        logic [PRODUCT_W-1:0] product;
    } sgdlr_mac_rsp_t;

endpackage

/* hdl/sgdlr_mac.sv */
// ----------------------------------------------------------------------------
// SGD trainer shared multiplier
// Unsigned 64 x 64 product built from four 32 x 32 partial products,
// one per cycle, accumulated into a 128-bit result.
// ----------------------------------------------------------------------------
module sgdlr_mac
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sgdlr_pkg::sgdlr_mac_req_t req,
    output sgdlr_pkg::sgdlr_mac_rsp_t rsp
);
    import sgdlr_pkg::*;

    logic [OPERAND_W-1:0]   a_reg;
    logic [OPERAND_W-1:0]   b_reg;
    logic [1:0]             cnt_reg;
    logic                   busy_reg;
    logic [2*CHUNK_W-1:0]   pp_reg;
    logic [1:0]             pp_shift_reg;
    logic                   pp_valid_reg;
    logic                   pp_last_reg;
    logic                   done_reg;
    logic [PRODUCT_W-1:0]   acc_reg;

    logic [CHUNK_W-1:0]     a_chunk;
    logic [CHUNK_W-1:0]     b_chunk;
    logic [2*CHUNK_W-1:0]   pp_next;
    logic [PRODUCT_W-1:0]   pp_aligned;

    assign a_chunk = cnt_reg[1] ? a_reg[OPERAND_W-1:CHUNK_W] : a_reg[CHUNK_W-1:0];
    assign b_chunk = cnt_reg[0] ? b_reg[OPERAND_W-1:CHUNK_W] : b_reg[CHUNK_W-1:0];
    assign pp_next = {{CHUNK_W{1'b0}}, a_chunk} * {{CHUNK_W{1'b0}}, b_chunk};

    always_comb
    begin
        case (pp_shift_reg)
            2'd0:    pp_aligned = {{(2*CHUNK_W){1'b0}}, pp_reg};
            2'd1:    pp_aligned = {{CHUNK_W{1'b0}}, pp_reg, {CHUNK_W{1'b0}}};
            2'd2:    pp_aligned = {pp_reg, {(2*CHUNK_W){1'b0}}};
            default: pp_aligned = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            pp_valid_reg <= 1'b0;
            pp_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= pp_valid_reg && pp_last_reg;
            pp_valid_reg <= busy_reg;
            pp_last_reg  <= busy_reg && (cnt_reg == 2'd3);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (pp_valid_reg)
        begin
            acc_reg <= acc_reg + pp_aligned;
        end
        if (busy_reg)
        begin
            pp_reg       <= pp_next;
            pp_shift_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

/* hdl/sgd_linear_regression_trainer.sv */
// ----------------------------------------------------------------------------
// SGD linear regression trainer
// Online LMS regression with a bias and two features, run on one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One item is in work at a time; sample_stall stays high from acceptance until
// the result is written to the output register. Every product goes through the
// shared 64 x 64 multiplier, which builds it from four 32 x 32 partial products
// plus launch and drain. A train item that updates the weights needs twelve
// products, a train item on a converged block three, a predict item two, and a
// reload or an unknown command none. A result waiting in the output register
// does not hold off the next item; only the final write waits for the register
// to free.
module sgd_linear_regression_trainer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic [1:0]         command,
    input  logic [15:0]        feature_one,
    input  logic [15:0]        feature_two,
    input  logic signed [31:0] target,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [47:0] prediction,
    output logic [47:0]        cost_before,
    output logic [47:0]        cost_after,
    output logic               updated,
    output logic               converged
);
    import sgdlr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED_MUL,
        ST_PRED_FIN,
        ST_COST_MUL,
        ST_STEP_FEAT,
        ST_STEP_RATE,
        ST_EMIT
    } state_t;

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111)
        begin
            r = v[47:0];
        end
        else if (v[50])
        begin
            r = 48'sh8000_0000_0000;
        end
        else
        begin
            r = 48'sh7FFF_FFFF_FFFF;
        end
        return r;
    endfunction

    // configuration
    logic [39:0]        learning_rate_reg;
    logic [47:0]        cost_threshold_reg;
    logic signed [47:0] initial_bias_reg;
    logic signed [47:0] initial_weight_one_reg;
    logic signed [47:0] initial_weight_two_reg;

    // sequencer state
    state_t             state_reg, state_next;
    logic signed [47:0] w0_reg, w0_next;
    logic signed [47:0] w1_reg, w1_next;
    logic signed [47:0] w2_reg, w2_next;
    logic               done_flag_reg, done_flag_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [15:0]        x1_reg, x1_next;
    logic [15:0]        x2_reg, x2_next;
    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [66:0] sum_reg, sum_next;
    logic               term_reg, term_next;
    logic               pass_reg, pass_next;
    logic [1:0]         wsel_reg, wsel_next;
    logic               err_neg_reg, err_neg_next;
    logic [47:0]        err_mag_reg, err_mag_next;
    logic [63:0]        feat_prod_reg, feat_prod_next;
    logic signed [47:0] pred_reg, pred_next;
    logic [47:0]        cb_reg, cb_next;
    logic [47:0]        ca_reg, ca_next;
    logic               upd_reg, upd_next;
    logic               issued_reg, issued_next;
    logic               result_valid_reg, result_valid_next;
    logic signed [47:0] res_prediction_reg, res_prediction_next;
    logic [47:0]        res_cost_before_reg, res_cost_before_next;
    logic [47:0]        res_cost_after_reg, res_cost_after_next;
    logic               res_updated_reg, res_updated_next;
    logic               res_converged_reg, res_converged_next;

    sgdlr_mac_req_t     mac_req;
    sgdlr_mac_rsp_t     mac_rsp;

    logic signed [47:0] w_term;
    logic [15:0]        x_term;
    logic [47:0]        w_term_mag;
    logic signed [47:0] w_sel;
    logic [15:0]        f_sel;
    logic signed [66:0] term_prod;
    logic signed [66:0] sum_acc;
    logic signed [66:0] sum_rnd;
    logic signed [47:0] pred_sat;
    logic signed [48:0] err;
    logic signed [48:0] err_neg_val;
    logic [47:0]        err_mag;
    logic [127:0]       cost_q;
    logic [47:0]        cost_val;
    logic [127:0]       step_v;
    logic [49:0]        step_d;
    logic signed [50:0] w_ext;
    logic signed [50:0] d_ext;
    logic signed [47:0] w_new;

    sgdlr_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .rsp   (mac_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg      <= LEARNING_RATE_RESET;
            cost_threshold_reg     <= COST_THRESHOLD_RESET;
            initial_bias_reg       <= INITIAL_BIAS_RESET;
            initial_weight_one_reg <= INITIAL_WEIGHT_ONE_RESET;
            initial_weight_two_reg <= INITIAL_WEIGHT_TWO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEARNING_RATE:      learning_rate_reg      <= cfg_data[39:0];
                CFG_COST_THRESHOLD:     cost_threshold_reg     <= cfg_data;
                CFG_INITIAL_BIAS:       initial_bias_reg       <= cfg_data;
                CFG_INITIAL_WEIGHT_ONE: initial_weight_one_reg <= cfg_data;
                CFG_INITIAL_WEIGHT_TWO: initial_weight_two_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // datapath around the shared multiplier
    assign w_term     = term_reg ? w2_reg : w1_reg;
    assign x_term     = term_reg ? x2_reg : x1_reg;
    assign w_term_mag = w_term[47] ? 48'(-w_term) : w_term;
    assign term_prod  = {3'b000, mac_rsp.product[63:0]};
    assign sum_acc    = w_term[47] ? sum_reg - term_prod : sum_reg + term_prod;

    assign sum_rnd     = sum_reg + 67'sd32768;
    assign pred_sat    = sat48(sum_rnd[66:16]);
    assign err         = {{17{tgt_reg[31]}}, tgt_reg} - {pred_sat[47], pred_sat};
    assign err_neg_val = -err;
    assign err_mag     = err[48] ? err_neg_val[47:0] : err[47:0];

    assign cost_q   = mac_rsp.product + 128'h1_0000;
    assign cost_val = (|cost_q[127:65]) ? {48{1'b1}} : cost_q[64:17];

    always_comb
    begin
        case (wsel_reg)
            2'd0:    begin w_sel = w0_reg; f_sel = 16'd1;  end
            2'd1:    begin w_sel = w1_reg; f_sel = x1_reg; end
            default: begin w_sel = w2_reg; f_sel = x2_reg; end
        endcase
    end

    assign step_v = mac_rsp.product + 128'h8000_0000;
    assign step_d = (|step_v[127:80]) ? 50'h2_0000_0000_0000 : {2'b00, step_v[79:32]};
    assign w_ext  = {{3{w_sel[47]}}, w_sel};
    assign d_ext  = {1'b0, step_d};
    assign w_new  = sat48(err_neg_reg ? w_ext - d_ext : w_ext + d_ext);

    always_comb
    begin
        mac_req.a = '0;
        mac_req.b = '0;
        case (state_reg)
            ST_PRED_MUL:
            begin
                mac_req.a = {16'd0, w_term_mag};
                mac_req.b = {48'd0, x_term};
            end
            ST_COST_MUL:
            begin
                mac_req.a = {16'd0, err_mag_reg};
                mac_req.b = {16'd0, err_mag_reg};
            end
            ST_STEP_FEAT:
            begin
                mac_req.a = {16'd0, err_mag_reg};
                mac_req.b = {48'd0, f_sel};
            end
            ST_STEP_RATE:
            begin
                mac_req.a = feat_prod_reg;
                mac_req.b = {24'd0, learning_rate_reg};
            end
            default:
            begin
                mac_req.a = '0;
                mac_req.b = '0;
            end
        endcase
        mac_req.start = !issued_reg &&
                        (state_reg == ST_PRED_MUL || state_reg == ST_COST_MUL ||
                         state_reg == ST_STEP_FEAT || state_reg == ST_STEP_RATE);
    end

    always_comb
    begin
        state_next           = state_reg;
        w0_next              = w0_reg;
        w1_next              = w1_reg;
        w2_next              = w2_reg;
        done_flag_next       = done_flag_reg;
        cmd_next             = cmd_reg;
        x1_next              = x1_reg;
        x2_next              = x2_reg;
        tgt_next             = tgt_reg;
        sum_next             = sum_reg;
        term_next            = term_reg;
        pass_next            = pass_reg;
        wsel_next            = wsel_reg;
        err_neg_next         = err_neg_reg;
        err_mag_next         = err_mag_reg;
        feat_prod_next       = feat_prod_reg;
        pred_next            = pred_reg;
        cb_next              = cb_reg;
        ca_next              = ca_reg;
        upd_next             = upd_reg;
        issued_next          = issued_reg;
        result_valid_next    = result_valid_reg;
        res_prediction_next  = res_prediction_reg;
        res_cost_before_next = res_cost_before_reg;
        res_cost_after_next  = res_cost_after_reg;
        res_updated_next     = res_updated_reg;
        res_converged_next   = res_converged_reg;

        if (mac_req.start)
        begin
            issued_next = 1'b1;
        end
        if (mac_rsp.done)
        begin
            issued_next = 1'b0;
        end
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd_next  = command;
                    x1_next   = feature_one;
                    x2_next   = feature_two;
                    tgt_next  = target;
                    sum_next  = {{19{w0_reg[47]}}, w0_reg};
                    term_next = 1'b0;
                    pass_next = 1'b0;
                    pred_next = '0;
                    cb_next   = '0;
                    ca_next   = '0;
                    upd_next  = 1'b0;
                    case (command)
                        CMD_TRAIN, CMD_PREDICT:
                        begin
                            state_next = ST_PRED_MUL;
                        end
                        CMD_RELOAD:
                        begin
                            w0_next        = initial_bias_reg;
                            w1_next        = initial_weight_one_reg;
                            w2_next        = initial_weight_two_reg;
                            done_flag_next = 1'b0;
                            state_next     = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_PRED_MUL:
            begin
                if (mac_rsp.done)
                begin
                    sum_next = sum_acc;
                    if (term_reg)
                    begin
                        state_next = ST_PRED_FIN;
                    end
                    else
                    begin
                        term_next = 1'b1;
                    end
                end
            end

            ST_PRED_FIN:
            begin
                err_neg_next = err[48];
                err_mag_next = err_mag;
                state_next   = ST_COST_MUL;
                if (!pass_reg)
                begin
                    pred_next = pred_sat;
                    if (cmd_reg == CMD_PREDICT)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_COST_MUL:
            begin
                if (mac_rsp.done)
                begin
                    if (!pass_reg)
                    begin
                        cb_next = cost_val;
                        if (done_flag_reg)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            wsel_next  = 2'd0;
                            state_next = ST_STEP_FEAT;
                        end
                    end
                    else
                    begin
                        ca_next  = cost_val;
                        upd_next = 1'b1;
                        if (cost_val <= cost_threshold_reg)
                        begin
                            done_flag_next = 1'b1;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_STEP_FEAT:
            begin
                if (mac_rsp.done)
                begin
                    feat_prod_next = mac_rsp.product[63:0];
                    state_next     = ST_STEP_RATE;
                end
            end

            ST_STEP_RATE:
            begin
                if (mac_rsp.done)
                begin
                    case (wsel_reg)
                        2'd0:    w0_next = w_new;
                        2'd1:    w1_next = w_new;
                        default: w2_next = w_new;
                    endcase
                    if (wsel_reg == 2'd2)
                    begin
                        pass_next  = 1'b1;
                        term_next  = 1'b0;
                        sum_next   = {{19{w0_reg[47]}}, w0_reg};
                        state_next = ST_PRED_MUL;
                    end
                    else
                    begin
                        wsel_next  = wsel_reg + 2'd1;
                        state_next = ST_STEP_FEAT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next    = 1'b1;
                    res_prediction_next  = pred_reg;
                    res_cost_before_next = cb_reg;
                    res_cost_after_next  = ca_reg;
                    res_updated_next     = upd_reg;
                    res_converged_next   = done_flag_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            w0_reg              <= INITIAL_BIAS_RESET;
            w1_reg              <= INITIAL_WEIGHT_ONE_RESET;
            w2_reg              <= INITIAL_WEIGHT_TWO_RESET;
            done_flag_reg       <= 1'b0;
            cmd_reg             <= CMD_TRAIN;
            x1_reg              <= '0;
            x2_reg              <= '0;
            tgt_reg             <= '0;
            sum_reg             <= '0;
            term_reg            <= 1'b0;
            pass_reg            <= 1'b0;
            wsel_reg            <= 2'd0;
            err_neg_reg         <= 1'b0;
            err_mag_reg         <= '0;
            feat_prod_reg       <= '0;
            pred_reg            <= '0;
            cb_reg              <= '0;
            ca_reg              <= '0;
            upd_reg             <= 1'b0;
            issued_reg          <= 1'b0;
            result_valid_reg    <= 1'b0;
            res_prediction_reg  <= '0;
            res_cost_before_reg <= '0;
            res_cost_after_reg  <= '0;
            res_updated_reg     <= 1'b0;
            res_converged_reg   <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            w0_reg              <= w0_next;
            w1_reg              <= w1_next;
            w2_reg              <= w2_next;
            done_flag_reg       <= done_flag_next;
            cmd_reg             <= cmd_next;
            x1_reg              <= x1_next;
            x2_reg              <= x2_next;
            tgt_reg             <= tgt_next;
            sum_reg             <= sum_next;
            term_reg            <= term_next;
            pass_reg            <= pass_next;
            wsel_reg            <= wsel_next;
            err_neg_reg         <= err_neg_next;
            err_mag_reg         <= err_mag_next;
            feat_prod_reg       <= feat_prod_next;
            pred_reg            <= pred_next;
            cb_reg              <= cb_next;
            ca_reg              <= ca_next;
            upd_reg             <= upd_next;
            issued_reg          <= issued_next;
            result_valid_reg    <= result_valid_next;
            res_prediction_reg  <= res_prediction_next;
            res_cost_before_reg <= res_cost_before_next;
            res_cost_after_reg  <= res_cost_after_next;
            res_updated_reg     <= res_updated_next;
            res_converged_reg   <= res_converged_next;
        end
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign prediction   = res_prediction_reg;
    assign cost_before  = res_cost_before_reg;
    assign cost_after   = res_cost_after_reg;
    assign updated      = res_updated_reg;
    assign converged    = res_converged_reg;

endmodule

/* hdl/sgdlr_checker.sv */
// ----------------------------------------------------------------------------
// SGD trainer port checker
// Watches the trainer's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sgdlr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [47:0] prediction,
    input logic [47:0]        cost_before,
    input logic [47:0]        cost_after,
    input logic               updated,
    input logic               converged
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result transaction dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(prediction) && $stable(cost_before) && $stable(cost_after) &&
            $stable(updated) && $stable(converged))
        else $error("result payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample accepted without entering the busy phase");

    a_no_update_no_cost: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !updated |-> cost_after == 48'd0)
        else $error("cost_after nonzero on a transaction without update");

endmodule

bind sgd_linear_regression_trainer sgdlr_checker u_sgdlr_checker (.*);
